/* rtl/core/kls_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kls_pkg: shared types and constants of the kth largest stream tracker
// Holds the configuration register layout and the per-cell control bundle.
// ----------------------------------------------------------------------------
package kls_pkg;

   // Width of the rank register as seen by software.
   localparam int K_COUNT_WIDTH = 7;

   // Configuration register file layout.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ADDR_K_COUNT = 3'd0;

   // Rank after reset.
   localparam logic [K_COUNT_WIDTH-1:0] K_COUNT_RESET = 7'd1;

   // Control handed from the top level to every cell.
   typedef struct packed {
      logic load;   // an item is being inserted this cycle
      logic live;   // the cell currently holds a kept value
   } cell_ctrl_type;

endpackage
`default_nettype wire

/* rtl/core/kth_largest_stream_tracker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kth_largest_stream_tracker: keeps the k largest values of a stream
// A chain of MAX_K cells holds the kept values in descending order.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a value on req_new_value; the item is taken at the
//   rising edge where start is high and busy is low. busy stays low, so
//   one item is taken in every cycle.
//   Every item gives one result in the next cycle: rsp_strobe is high for one
//   cycle with rsp_kth_value (smallest kept value) and rsp_full_res (k values
//   held). The receiver cannot stall the block; results must be taken as
//   they appear.
//   The insertion compares the item against every cell in parallel and the
//   chain shifts in the same cycle; the result is selected from the cells'
//   next values at the new fill count.
//   The rank k is written over the APB port at byte address 0 while idle.
//   A rank of 0 acts as 1, one above MAX_K acts as MAX_K.
//   Reset empties the store (fill count zero) and sets the rank to 1; the
//   cell contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module kth_largest_stream_tracker #(
   parameter int MAX_K       = 64,
   parameter int VALUE_WIDTH = 16
) (
   input  wire                                     clock,
   input  wire                                     reset,
   // Item input
   input  wire                                     start,
   output logic                                    busy,
   input  wire signed [VALUE_WIDTH-1:0]            req_new_value,
   // Result output
   output logic                                    rsp_strobe,
   output logic signed [VALUE_WIDTH-1:0]           rsp_kth_value,
   output logic                                    rsp_full_res,
   // Configuration port
   input  wire                                     psel,
   input  wire                                     penable,
   input  wire                                     pwrite,
   input  wire [kls_pkg::CSR_ADDR_WIDTH-1:0]       paddr,
   input  wire [kls_pkg::CSR_DATA_WIDTH-1:0]       pwdata,
   output logic [kls_pkg::CSR_DATA_WIDTH-1:0]      prdata,
   output logic                                    pready
);
   import kls_pkg::*;

   // Count range 0..MAX_K+1 and a common width for rank comparisons.
   localparam int CNT_W = $clog2(MAX_K + 2);
   localparam int EW    = (CNT_W > K_COUNT_WIDTH) ? CNT_W : K_COUNT_WIDTH;

   logic [K_COUNT_WIDTH-1:0]      k_count_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic                          rsp_strobe_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_kth_value_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_kth_value_in;
   logic                          rsp_full_res_ff;
   logic                          accept;
   logic                          csr_write;
   logic                          csr_hit_k;
   logic [EW-1:0]                 k_wide;
   logic [EW-1:0]                 k_eff_wide;
   logic [CNT_W-1:0]              k_eff;
   logic [CNT_W-1:0]              count_inc;
   logic [CNT_W-1:0]              kth_index;

   logic                          link_ge    [0:MAX_K];
   logic signed [VALUE_WIDTH-1:0] link_value [0:MAX_K];
   logic signed [VALUE_WIDTH-1:0] cell_next  [0:MAX_K-1];
   cell_ctrl_type                 cell_ctrl  [0:MAX_K-1];

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign accept = start && !busy;

   // Configuration register write and read back.
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_hit_k = (paddr[CSR_ADDR_WIDTH-1:2] == CSR_ADDR_K_COUNT[CSR_ADDR_WIDTH-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_count_ff <= K_COUNT_RESET;
      end else if (csr_write && csr_hit_k) begin
         k_count_ff <= pwdata[K_COUNT_WIDTH-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (csr_hit_k) begin
         prdata[K_COUNT_WIDTH-1:0] = k_count_ff;
      end
   end

   // Effective rank: zero acts as one, anything above MAX_K as MAX_K.
   assign k_wide = EW'(k_count_ff);

   always_comb begin
      priority if (k_wide == '0) begin
         k_eff_wide = EW'(1);
      end else if (k_wide > EW'(MAX_K)) begin
         k_eff_wide = EW'(MAX_K);
      end else begin
         k_eff_wide = k_wide;
      end
   end

   assign k_eff = k_eff_wide[CNT_W-1:0];

   // New fill count: one more, trimmed to the rank.
   assign count_inc = count_ff + CNT_W'(1);
   assign count_in  = (count_inc > k_eff) ? k_eff : count_inc;
   assign kth_index = count_in - CNT_W'(1);

   // Head of the chain: anything above the first cell is not below the item.
   assign link_ge[0]    = 1'b1;
   assign link_value[0] = req_new_value;

   // Chain of cells, largest value in cell zero.
   for (genvar gi = 0; gi < MAX_K; gi++) begin : g_cell
      assign cell_ctrl[gi].load = accept;
      assign cell_ctrl[gi].live = (CNT_W'(gi) < count_ff);

      kls_cell #(
         .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[gi]),
         .new_value  (req_new_value),
         .prev_ge    (link_ge[gi]),
         .prev_value (link_value[gi]),
         .this_ge    (link_ge[gi+1]),
         .this_value (link_value[gi+1]),
         .next_value (cell_next[gi])
      );
   end

   // Smallest kept value sits in the last live cell after the insertion.
   always_comb begin
      rsp_kth_value_in = '0;
      for (int i = 0; i < MAX_K; i++) begin
         if (kth_index == CNT_W'(i)) begin
            rsp_kth_value_in = rsp_kth_value_in | cell_next[i];
         end
      end
   end

   // Fill count and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_kth_value_ff <= rsp_kth_value_in;
         rsp_full_res_ff  <= (count_in == k_eff);
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_kth_value = rsp_kth_value_ff;
   assign rsp_full_res  = rsp_full_res_ff;

endmodule
`default_nettype wire

/* rtl/core/kls_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kls_cell: one slot of the descending sorted chain
// Compares its value against the incoming item and keeps it, takes the
// item, or takes its upper neighbor's value as the chain shifts down.
// ----------------------------------------------------------------------------
module kls_cell #(
   parameter int VALUE_WIDTH = 16
) (
   input  wire                          clock,
   input  kls_pkg::cell_ctrl_type       ctrl,
   input  wire signed [VALUE_WIDTH-1:0] new_value,
   input  wire                          prev_ge,
   input  wire signed [VALUE_WIDTH-1:0] prev_value,
   output logic                         this_ge,
   output logic signed [VALUE_WIDTH-1:0] this_value,
   output logic signed [VALUE_WIDTH-1:0] next_value
);
   import kls_pkg::*;

   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] value_in;

   // A live value not below the item stays above the insertion point.
   assign this_ge    = ctrl.live && (value_ff >= new_value);
   assign this_value = value_ff;

   // Keep, take the item at the insertion point, or shift down from above.
   always_comb begin
      if (this_ge) begin
         value_in = value_ff;
      end else if (prev_ge) begin
         value_in = new_value;
      end else begin
         value_in = prev_value;
      end
   end

   assign next_value = value_in;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         value_ff <= value_in;
      end
   end

endmodule
`default_nettype wire

/* sim/tb_kth_largest_stream_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kth_largest_stream_tracker: self-checking bench for the kth largest tracker
// Streams signed values through the command port and predicts each result
// from its own sorted copy of the kept values. The rank is reprogrammed over
// APB between phases. Directed cases come first, then long random phases.
// ----------------------------------------------------------------------------
module tb_kth_largest_stream_tracker;
   import kls_pkg::*;

   localparam int VALUE_W        = 16;
   localparam int MAX_RANK       = 64;
   localparam int RANDOM_ITEMS   = 1150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_TAIL     = 10;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ADDR_UNMAPPED = 3'd4;

   typedef logic signed [VALUE_W-1:0] value_type;

   // One predicted result.
   typedef struct {
      value_type kth_value;
      logic      full_res;
   } rank_result_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   value_type                 req_new_value;
   logic                      rsp_strobe;
   value_type                 rsp_kth_value;
   logic                      rsp_full_res;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   // Predictor state: kept values in ascending order and the rank register.
   value_type                 kept_sorted[$];
   logic [K_COUNT_WIDTH-1:0]  rank_reg = K_COUNT_RESET;
   rank_result_type           pending_results[$];

   int                        items_taken     = 0;
   int                        results_checked = 0;
   int                        csr_write_count = 0;
   int                        csr_read_count  = 0;
   int                        rank_settings   = 0;
   int                        error_count     = 0;
   int                        idle_cycles     = 0;
   int                        burst_left      = 0;
   logic [CSR_DATA_WIDTH-1:0] csr_read_data;
   logic                      cycle_active;

   kth_largest_stream_tracker #(
      .MAX_K       (MAX_RANK),
      .VALUE_WIDTH (VALUE_W)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_new_value (req_new_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_kth_value (rsp_kth_value),
      .rsp_full_res  (rsp_full_res),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Rank as the block applies it: zero acts as one, large values clamp.
   function automatic int effective_rank();
      if (rank_reg == 0) return 1;
      if (rank_reg > MAX_RANK) return MAX_RANK;
      return int'(rank_reg);
   endfunction

   // Insert one value into the kept set and queue the result it yields.
   function automatic void track_value(input value_type value);
      int              pos;
      int              rank;
      rank_result_type res;
      rank = effective_rank();
      pos  = kept_sorted.size();
      while (pos > 0 && kept_sorted[pos-1] > value) pos--;
      kept_sorted.insert(pos, value);
      while (kept_sorted.size() > rank) void'(kept_sorted.pop_front());
      res.kth_value = kept_sorted[0];
      res.full_res  = (kept_sorted.size() == rank);
      pending_results.push_back(res);
   endfunction

   // Watch the ports at every rising edge: items, results and register accesses.
   always @(posedge clock) begin
      if (!reset) begin
         cycle_active = 1'b0;
         if (start && !busy) begin
            track_value(req_new_value);
            items_taken++;
            cycle_active = 1'b1;
         end
         if (rsp_strobe) begin
            cycle_active = 1'b1;
            if (pending_results.size() == 0) begin
               $error("result with no item outstanding: kth_value %0d, full_res %0b",
                      rsp_kth_value, rsp_full_res);
               error_count++;
            end else begin
               rank_result_type exp_res;
               exp_res = pending_results.pop_front();
               results_checked++;
               if (rsp_kth_value !== exp_res.kth_value) begin
                  $error("kth_value mismatch: expected %0d, actual %0d",
                         exp_res.kth_value, rsp_kth_value);
                  error_count++;
               end
               if (rsp_full_res !== exp_res.full_res) begin
                  $error("full_res mismatch: expected %0b, actual %0b",
                         exp_res.full_res, rsp_full_res);
                  error_count++;
               end
            end
         end
         if (psel && penable && pready) begin
            cycle_active = 1'b1;
            if (pwrite) begin
               if (paddr == CSR_ADDR_K_COUNT) rank_reg = pwdata[K_COUNT_WIDTH-1:0];
               csr_write_count++;
            end else begin
               csr_read_data = prdata;
               csr_read_count++;
            end
         end
         idle_cycles = cycle_active ? 0 : idle_cycles + 1;
      end
   end

   // Watchdog: ends the run if nothing moves for too long.
   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("Timeout after %0d idle cycles.", idle_cycles);
      $display("== FAIL ==");
      $finish;
   end

   // Sender idle time: mostly random gaps, with occasional back-to-back bursts.
   function automatic int draw_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         burst_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   // Value mix: full range, a narrow cluster for duplicates, and the extremes.
   function automatic value_type draw_value();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 12) return value_type'($urandom());
      if (sel < 17) return value_type'($urandom_range(0, 15)) - value_type'(8);
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh8001;
         2: return -16'sd1;
         3: return 16'sd0;
         4: return 16'sh7FFE;
         default: return 16'sh7FFF;
      endcase
   endfunction

   // Send one item; entered and left at a falling edge.
   task automatic send_value(input value_type value);
      int ticket;
      int gap;
      ticket = items_taken + 1;
      gap    = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start         <= 1'b1;
      req_new_value <= value;
      do @(negedge clock); while (items_taken < ticket);
   endtask

   // Hold the sender off until every outstanding result has come back.
   task automatic wait_drain();
      start <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      int ticket;
      ticket  = csr_write_count + 1;
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (csr_write_count < ticket);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Read the rank register back and compare it with the predicted value.
   task automatic check_rank_readback();
      int ticket;
      ticket  = csr_read_count + 1;
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      paddr   <= CSR_ADDR_K_COUNT;
      @(negedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (csr_read_count < ticket);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      if (csr_read_data !== CSR_DATA_WIDTH'(rank_reg)) begin
         $error("k_count readback mismatch: expected %0d, actual %0d",
                rank_reg, csr_read_data);
         error_count++;
      end
   endtask

   // Program a new rank once the block is idle; upper data bits are sometimes junk.
   task automatic set_rank(input int rank);
      logic [CSR_DATA_WIDTH-1:0] data;
      wait_drain();
      data = CSR_DATA_WIDTH'(rank);
      if ($urandom_range(0, 1) == 1) data |= $urandom() & 32'hFFFF_FF80;
      csr_write(CSR_ADDR_K_COUNT, data);
      rank_settings++;
      check_rank_readback();
   endtask

   // After reset the rank is one, so the first item fills the set.
   task automatic test_reset_defaults();
      check_rank_readback();
      send_value(16'sh7FFF);
   endtask

   // Field extremes and alternating bit patterns at rank one.
   task automatic test_value_extremes();
      send_value(16'sh8000);
      send_value(16'sd0);
      send_value(-16'sd1);
      send_value(16'sh5555);
      send_value(16'shAAAA);
   endtask

   // Raising the rank leaves the set short of full; duplicates count separately.
   task automatic test_duplicates_not_full();
      set_rank(3);
      send_value(16'sd7);
      send_value(16'sd7);
      send_value(16'sd7);
      send_value(-16'sd5);
      send_value(16'sd8);
   endtask

   // A rank of zero behaves as rank one.
   task automatic test_rank_zero();
      set_rank(0);
      send_value(16'sd3);
      send_value(-16'sd3);
   endtask

   // A rank above the store size clamps to the store size.
   task automatic test_rank_above_max();
      set_rank(100);
      send_value(16'sd20);
      send_value(-16'sd20);
      send_value(16'sd0);
   endtask

   // Lowering the rank below the fill makes the next item drop several values.
   task automatic test_rank_lowered();
      set_rank(2);
      send_value(16'sd1);
      send_value(16'sd50);
   endtask

   // A write to an unmapped address must leave the rank alone.
   task automatic test_unmapped_write();
      wait_drain();
      csr_write(CSR_ADDR_UNMAPPED, 32'd9);
      check_rank_readback();
      send_value(16'sd100);
      send_value(-16'sd100);
   endtask

   // Random phases, each with its own rank; the first ones hit the rank extremes.
   task automatic test_random_phases();
      int phase;
      int sent;
      int count;
      int rank;
      phase = 0;
      sent  = 0;
      while (sent < RANDOM_ITEMS) begin
         case (phase)
            0: rank = MAX_RANK;
            1: rank = 127;
            2: rank = 0;
            3: rank = 1;
            default: begin
               case ($urandom_range(0, 7))
                  0: rank = 1;
                  1: rank = MAX_RANK;
                  2: rank = 0;
                  3: rank = $urandom_range(MAX_RANK + 1, 127);
                  4: rank = 2;
                  default: rank = $urandom_range(1, MAX_RANK);
               endcase
            end
         endcase
         set_rank(rank);
         count = effective_rank() + $urandom_range(20, 100);
         for (int i = 0; i < count && sent < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 149) == 0) wait_drain();
            send_value(draw_value());
            sent++;
         end
         phase++;
      end
   endtask

   // Main sequence.
   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_new_value = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_value_extremes();
      test_duplicates_not_full();
      test_rank_zero();
      test_rank_above_max();
      test_rank_lowered();
      test_unmapped_write();
      test_random_phases();

      wait_drain();
      repeat (DRAIN_TAIL) @(negedge clock);

      $display("Streamed %0d values across %0d rank settings; %0d results checked.",
               items_taken, rank_settings, results_checked);
      $display("Ranks covered zero, one, the store size and above; %0d errors seen.",
               error_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
